/* rtl/core/fau_pkg.sv */
`default_nettype none
package fau_pkg;
	localparam int unsigned OperandWidthDefault = 16;
	localparam int unsigned ResNumWidth = 32;
	localparam int unsigned ResDenWidth = 31;

	typedef enum logic [2:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_RED = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_FORM,
		ST_CHECK,
		ST_GCD,
		ST_QDIV_N,
		ST_QDIV_D,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic form;
		logic gcd_start;
		logic div_start_n;
		logic div_start_d;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic div_busy;
	} sts_t;
endpackage
`default_nettype wire

/* rtl/core/fraction_arithmetic_unit.sv */
// steps: load, mul1, mul2, form and check; a raw numerator or denominator of zero goes
//   straight to done, otherwise the euclid remainder steps run on the bit-serial divider,
//   DW = 2*OPERAND_WIDTH+2 bits wide, then numerator and denominator are divided by the gcd
// one transaction at a time: a new one is taken only once the last result is in the output register
// the finished result sits in an output register so a new transaction may enter
// reset: arst_n asynchronous, clears controller state and output valid
`default_nettype none
module fraction_arithmetic_unit import fau_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [2:0]               action,
	input  wire logic [OPERAND_WIDTH-1:0] a_num,
	input  wire logic [OPERAND_WIDTH-2:0] a_den,
	input  wire logic [OPERAND_WIDTH-1:0] b_num,
	input  wire logic [OPERAND_WIDTH-2:0] b_den,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [ResNumWidth-1:0]        res_num,
	output logic [ResDenWidth-1:0]        res_den,
	output logic                          div_zero
);
	cmd_t cmd;
	sts_t sts;

	fau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.action  (action),
		.a_num   (a_num),
		.a_den   (a_den),
		.b_num   (b_num),
		.b_den   (b_den),
		.res_num (res_num),
		.res_den (res_den),
		.div_zero(div_zero)
	);

	a_err_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_zero |-> res_den == '0 && res_num == '0)
		else $error("error result not zero");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !div_zero |-> res_den != '0)
		else $error("zero denominator without error");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.form, cmd.out_load}))
		else $error("overlapping commands");
endmodule
`default_nettype wire

/* rtl/core/fau_divider.sv */
`default_nettype none
module fau_divider import fau_pkg::*; #(
	parameter int unsigned W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              busy,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

/* rtl/core/fau_datapath.sv */
`default_nettype none
module fau_datapath import fau_pkg::*; #(
	parameter int unsigned OPERAND_WIDTH = OperandWidthDefault
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output sts_t                          sts,
	input  wire logic [2:0]               action,
	input  wire logic [OPERAND_WIDTH-1:0] a_num,
	input  wire logic [OPERAND_WIDTH-2:0] a_den,
	input  wire logic [OPERAND_WIDTH-1:0] b_num,
	input  wire logic [OPERAND_WIDTH-2:0] b_den,
	output logic [ResNumWidth-1:0]        res_num,
	output logic [ResDenWidth-1:0]        res_den,
	output logic                          div_zero
);
	localparam int unsigned OW = OPERAND_WIDTH;
	localparam int unsigned PW = 2 * OW + 1;
	localparam int unsigned MW = 2 * OW + 2;

	logic [2:0]             act_q;
	logic signed [OW-1:0]   an_q, bn_q;
	logic signed [OW:0]     ad_q, bd_q;
	logic signed [PW-1:0]   p1_q, p2_q, p3_q;
	logic signed [MW-1:0]   n_q, d_q;
	logic                   neg_q;
	logic [MW-1:0]          rn_q, rd_q, gx_q, gy_q;
	logic                   gcd_run_q;
	logic                   div_pend_q;
	logic                   gcd_issue;
	logic                   den_zero, num_zero;
	logic [MW-1:0]          div_a, div_b, quo, rem;
	logic                   div_busy, div_start;
	logic signed [OW:0]     ml_a, ml_b;
	logic signed [PW-1:0]   ml_p;
	logic signed [MW-1:0]   n_raw, d_raw;
	logic [MW-1:0]          rn_fix;

	// one shared multiplier for the mul1 and mul2 products; p1 is formed at load by its own multiply
	always_comb begin
		ml_a = {an_q[OW-1], an_q};
		ml_b = bd_q;
		if (cmd.mul1) begin
			ml_a = ad_q;
			ml_b = (action_t'(act_q) == ACT_DIV) ? {bn_q[OW-1], bn_q} : bd_q;
		end else if (cmd.mul2) begin
			ml_a = ad_q;
			ml_b = {bn_q[OW-1], bn_q};
			if (action_t'(act_q) == ACT_MUL) ml_a = {an_q[OW-1], an_q};
		end
	end
	assign ml_p = PW'(ml_a * ml_b);

	always_comb begin
		case (act_q)
			ACT_ADD: begin n_raw = MW'(p1_q) + MW'(p3_q); d_raw = MW'(p2_q); end
			ACT_SUB: begin n_raw = MW'(p1_q) - MW'(p3_q); d_raw = MW'(p2_q); end
			ACT_MUL: begin n_raw = MW'(p3_q); d_raw = MW'(p2_q); end
			ACT_DIV: begin n_raw = MW'(p1_q); d_raw = MW'(p2_q); end
			default: begin n_raw = MW'(an_q); d_raw = MW'(ad_q); end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			an_q  <= a_num;
			ad_q  <= {1'b0, a_den};
			bn_q  <= b_num;
			bd_q  <= {1'b0, b_den};
		end
		if (cmd.load) p1_q <= PW'($signed(a_num) * $signed({1'b0, b_den}));
		if (cmd.mul1) p2_q <= ml_p;
		if (cmd.mul2) p3_q <= ml_p;
		if (cmd.form) begin
			n_q <= n_raw;
			d_q <= d_raw;
		end
	end

	// gcd by repeated remainder using the shared divider
	// div_pend_q marks a gcd remainder issued and not yet taken
	assign gcd_issue = gcd_run_q && !div_busy && !div_pend_q && gy_q != '0;
	assign div_start = cmd.gcd_start || gcd_issue || cmd.div_start_n || cmd.div_start_d;
	always_comb begin
		div_a = gx_q;
		div_b = gy_q;
		if (cmd.gcd_start) begin
			div_a = n_q[MW-1] ? -n_q : n_q;
			div_b = d_q[MW-1] ? -d_q : d_q;
		end else if (cmd.div_start_n) begin
			div_a = rn_q;
			div_b = gx_q;
		end else if (cmd.div_start_d) begin
			div_a = rd_q;
			div_b = gx_q;
		end
	end

	fau_divider #(.W(MW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.quotient (quo),
		.remainder(rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcd_run_q  <= 1'b0;
			div_pend_q <= 1'b0;
		end else begin
			if (cmd.gcd_start || gcd_issue) div_pend_q <= 1'b1;
			else if (gcd_run_q && !div_busy && div_pend_q) div_pend_q <= 1'b0;
			if (cmd.gcd_start) gcd_run_q <= 1'b1;
			else if (gcd_run_q && !div_busy && !div_pend_q && gy_q == '0) gcd_run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gcd_start) begin
			rn_q  <= n_q[MW-1] ? -n_q : n_q;
			rd_q  <= d_q[MW-1] ? -d_q : d_q;
			gx_q  <= n_q[MW-1] ? -n_q : n_q;
			gy_q  <= d_q[MW-1] ? -d_q : d_q;
			neg_q <= n_q[MW-1] ^ d_q[MW-1];
		end else if (gcd_run_q && !div_busy && div_pend_q) begin
			gx_q <= gy_q;
			gy_q <= rem;
		end
		if (cmd.div_start_d && !div_busy) rn_q <= quo;
	end

	always_comb begin
		den_zero = (d_q == '0);
		num_zero = (n_q == '0);
	end

	assign rn_fix = neg_q ? -rn_q : rn_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (den_zero) begin
				res_num  <= '0;
				res_den  <= '0;
				div_zero <= 1'b1;
			end else if (num_zero) begin
				res_num  <= '0;
				res_den  <= ResDenWidth'(1);
				div_zero <= 1'b0;
			end else begin
				res_num  <= ResNumWidth'(rn_fix);
				res_den  <= ResDenWidth'(quo);
				div_zero <= 1'b0;
			end
		end
	end

	assign sts.den_zero = den_zero;
	assign sts.num_zero = num_zero;
	assign sts.div_busy = div_busy || div_pend_q || gcd_run_q;
endmodule
`default_nettype wire

/* rtl/core/fau_ctrl.sv */
`default_nettype none
module fau_ctrl import fau_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	state_t state_q, state_d;
	logic   ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL1;
				end
			end
			ST_MUL1: begin cmd.mul1 = 1'b1; state_d = ST_MUL2; end
			ST_MUL2: begin cmd.mul2 = 1'b1; state_d = ST_FORM; end
			ST_FORM: begin cmd.form = 1'b1; state_d = ST_CHECK; end
			ST_CHECK: begin
				if (sts.den_zero || sts.num_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.gcd_start = 1'b1;
					state_d       = ST_GCD;
				end
			end
			ST_GCD: begin
				if (!sts.div_busy) begin
					cmd.div_start_n = 1'b1;
					state_d         = ST_QDIV_N;
				end
			end
			ST_QDIV_N: begin
				if (!sts.div_busy) begin
					cmd.div_start_d = 1'b1;
					state_d         = ST_QDIV_D;
				end
			end
			ST_QDIV_D: begin
				if (!sts.div_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = ov_q;
endmodule
`default_nettype wire

/* tb/tb_fraction_arithmetic_unit.sv */
`default_nettype none
module tb_fraction_arithmetic_unit;
	import fau_pkg::*;

	localparam int unsigned W = OperandWidthDefault;

	typedef struct {
		logic [2:0]   act;
		logic [W-1:0] an;
		logic [W-2:0] ad;
		logic [W-1:0] bn;
		logic [W-2:0] bd;
	} frac_op_t;

	typedef struct {
		logic [ResNumWidth-1:0] num;
		logic [ResDenWidth-1:0] den;
		logic                   dz;
	} frac_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] action = '0;
	logic [W-1:0] a_num = '0;
	logic [W-2:0] a_den = '0;
	logic [W-1:0] b_num = '0;
	logic [W-2:0] b_den = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ResNumWidth-1:0] res_num;
	logic [ResDenWidth-1:0] res_den;
	logic div_zero;
	logic in_fire = 1'b0;

	frac_op_t op_queue[$];
	frac_res_t quotient_queue[$];
	int mismatches = 0;
	int in_gap = 0;
	int out_gap = 0;
	bit hold_send = 1'b0;

	fraction_arithmetic_unit #(.OPERAND_WIDTH(W)) DUT (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic frac_res_t reduce_fraction(frac_op_t op);
		frac_res_t r;
		longint n, d, an, ad, bn, bd;
		longint unsigned rn, rd, g;
		bit neg;
		an = longint'($signed(op.an));
		bn = longint'($signed(op.bn));
		ad = longint'(op.ad);
		bd = longint'(op.bd);
		case (op.act)
			ACT_ADD: begin n = an * bd + ad * bn; d = ad * bd; end
			ACT_SUB: begin n = an * bd - ad * bn; d = ad * bd; end
			ACT_MUL: begin n = an * bn; d = ad * bd; end
			ACT_DIV: begin n = an * bd; d = ad * bn; end
			default: begin n = an; d = ad; end
		endcase
		if (d == 0) begin
			r.num = '0;
			r.den = '0;
			r.dz = 1'b1;
			return r;
		end
		neg = (n < 0) != (d < 0);
		rn = (n < 0) ? -n : n;
		rd = (d < 0) ? -d : d;
		if (rn == 0) begin
			rd = 1;
			neg = 1'b0;
		end else begin
			g = euclid_gcd(rn, rd);
			rn = rn / g;
			rd = rd / g;
		end
		if (neg)
			rn = -rn;
		r.num = rn[ResNumWidth-1:0];
		r.den = rd[ResDenWidth-1:0];
		r.dz = 1'b0;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(20, 150);
	endfunction

	function automatic logic [W-1:0] rand_num();
		case ($urandom_range(0, 5))
			0: return {1'b1, {(W-1){1'b0}}};
			1: return {1'b0, {(W-1){1'b1}}};
			2: return W'($urandom_range(0, 20)) - W'(10);
			default: return W'($urandom);
		endcase
	endfunction

	function automatic logic [W-2:0] rand_den();
		case ($urandom_range(0, 5))
			0: return {(W-1){1'b1}};
			1: return (W-1)'($urandom_range(1, 12));
			default: return (W-1)'($urandom);
		endcase
	endfunction

	task automatic add_op(logic [2:0] act, logic [W-1:0] an, logic [W-2:0] ad,
			logic [W-1:0] bn, logic [W-2:0] bd);
		frac_op_t op;
		op.act = act;
		op.an = an;
		op.ad = ad;
		op.bn = bn;
		op.bd = bd;
		op_queue.push_back(op);
	endtask

	// input handshake as seen at the rising edge
	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
	end

	// driver
	always @(negedge clk) begin
		if (in_fire) begin
			quotient_queue.push_back(reduce_fraction(op_queue.pop_front()));
			in_gap = pick_gap();
		end
		if (in_fire || !in_valid) begin
			if (arst_n && !hold_send && in_gap == 0 && op_queue.size() > 0) begin
				in_valid <= 1'b1;
				action <= op_queue[0].act;
				a_num <= op_queue[0].an;
				a_den <= op_queue[0].ad;
				b_num <= op_queue[0].bn;
				b_den <= op_queue[0].bd;
			end else begin
				in_valid <= 1'b0;
				if (in_gap > 0)
					in_gap--;
			end
		end
		if (out_gap > 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else begin
			out_ready <= arst_n;
		end
	end

	// monitor
	always @(posedge clk) begin
		frac_res_t exp_r;
		if (out_valid && out_ready) begin
			out_gap = pick_gap();
			if (quotient_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %0d/%0d dz=%0b",
						$signed(res_num), res_den, div_zero);
			end else begin
				exp_r = quotient_queue.pop_front();
				if (res_num !== exp_r.num || res_den !== exp_r.den || div_zero !== exp_r.dz) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d dz=%0b got %0d/%0d dz=%0b",
							$signed(exp_r.num), exp_r.den, exp_r.dz,
							$signed(res_num), res_den, div_zero);
				end
			end
		end
	end

	initial begin
		int i;
		logic [2:0] act;
		logic [W-1:0] maxn;
		logic [W-1:0] minn;
		logic [W-2:0] maxd;
		maxn = {1'b0, {(W-1){1'b1}}};
		minn = {1'b1, {(W-1){1'b0}}};
		maxd = {(W-1){1'b1}};
		add_op(ACT_ADD, 1, 2, 1, 3);
		add_op(ACT_SUB, 1, 2, 1, 2);
		add_op(ACT_MUL, -2, 3, 3, 4);
		add_op(ACT_DIV, 3, 4, -9, 8);
		add_op(ACT_RED, 6, 8, 5, 7);
		add_op(ACT_DIV, 5, 7, 0, 3);
		add_op(ACT_MUL, 0, 5, 7, 9);
		add_op(ACT_RED, 0, 7, 0, 0);
		add_op(ACT_ADD, 1, 0, 1, 2);
		add_op(ACT_MUL, 3, 4, 5, 0);
		add_op(3'd5, 10, 4, 3, 3);
		add_op(3'd6, -10, 4, 0, 0);
		add_op(3'd7, maxn, maxd, minn, 1);
		add_op(ACT_ADD, maxn, maxd, maxn, maxd);
		add_op(ACT_SUB, minn, 1, maxn, 1);
		add_op(ACT_MUL, minn, 1, minn, 1);
		add_op(ACT_DIV, minn, maxd, minn, 1);
		add_op(ACT_DIV, maxn, 1, 1, maxd);
		add_op(ACT_ADD, minn, maxd, minn, maxd - 1);
		add_op(ACT_RED, minn, maxd, 0, 1);
		add_op(ACT_DIV, -1, 1, minn, 1);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (op_queue.size() == 0 && quotient_queue.size() == 0);
		// keep the sender idle while the random operations are queued
		hold_send = 1'b1;
		for (i = 0; i < 530; i++) begin
			act = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
			add_op(act, rand_num(), rand_den(), rand_num(), rand_den());
		end
		hold_send = 1'b0;
		wait (op_queue.size() == 0 && quotient_queue.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#100000000;
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire
